// ----- src/sacl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the set-associative LRU cache model.
// No dependencies; imported by sacl_pick, set_assoc_cache_lru_model and the testbench.
package sacl_pkg;

    // Port widths
    localparam int IN_DATA_W  = 64;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Line field widths
    localparam int TAG_W   = 64;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;

    // Access kinds
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

    // Configuration reset values
    localparam logic [2:0] SET_BITS_RST   = 3'd4;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_USED_RST  = 4'd1;

    typedef logic [STAMP_W-1:0] stamp_t;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        stamp_t             stamp;
    } line_t;

    // Add a small increment and stick at all ones on overflow
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {{(CNT_W-1){1'b0}}, n};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

// ----- src/sacl_pick.sv -----
`timescale 1ns / 1ps
// Way decision for one set: hit way, first empty way, or oldest way.
// Depends on sacl_pkg.
module sacl_pick #(
    parameter int MAX_WAYS = 8,
    parameter int WAY_W    = 3
) (
    input  logic [MAX_WAYS-1:0]                    match_v,
    input  logic [MAX_WAYS-1:0]                    empty_v,
    input  logic [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] age,
    output logic                                   hit,
    output logic                                   evict,
    output logic [WAY_W-1:0]                       way_sel
);
    import sacl_pkg::*;

    localparam int LV    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int P     = 1 << LV;
    localparam int NODES = 2 * P - 1;

    logic [WAY_W-1:0] match_idx;
    logic [WAY_W-1:0] empty_idx;
    logic [WAY_W-1:0] victim_idx;
    logic             has_empty;
    stamp_t           node_age [NODES];
    logic [WAY_W-1:0] node_idx [NODES];

    // Find the first matching and the first empty way
    always_comb
    begin
        match_idx = '0;
        empty_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match_v[w])
                match_idx = WAY_W'(w);
            if (empty_v[w])
                empty_idx = WAY_W'(w);
        end
    end

    // Tournament for the greatest age, left side wins a tie
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            if (i < MAX_WAYS)
                node_age[P-1+i] = age[i];
            else
                node_age[P-1+i] = '0;
            node_idx[P-1+i] = WAY_W'(i);
        end
        for (int i = P - 2; i >= 0; i--)
        begin
            if (node_age[2*i+2] > node_age[2*i+1])
            begin
                node_age[i] = node_age[2*i+2];
                node_idx[i] = node_idx[2*i+2];
            end
            else
            begin
                node_age[i] = node_age[2*i+1];
                node_idx[i] = node_idx[2*i+1];
            end
        end
    end

    // An all-zero age field leaves way zero as the victim
    assign victim_idx = (node_age[0] == '0) ? '0 : node_idx[0];

    // Choose the way to stamp
    assign hit       = |match_v;
    assign has_empty = |empty_v;
    assign evict     = !hit && !has_empty;
    assign way_sel   = hit ? match_idx : (has_empty ? empty_idx : victim_idx);

endmodule

// ----- src/set_assoc_cache_lru_model.sv -----
`timescale 1ns / 1ps
// Steps: row read, tag check, decide/write. A new access is taken only as the previous
// one leaves the decide/write step, set by the read-modify-write of one set row in the
// line memory; a back-to-back access to the same set takes forwarded row data. Reset:
// counters, clock and config return to defaults, then a sweep clears the valid bits one
// set per cycle with s_tready low; cfg is always ready.
module set_assoc_cache_lru_model #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Access in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sacl_pkg::IN_DATA_W-1:0]    s_tdata,   // [63:0] address
    input  logic [sacl_pkg::KIND_W-1:0]       s_tuser,   // [1:0] kind
    // Outcome out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] hit, [1] miss, [2] eviction, [3] second_hit, [35:4] hit_total,
    // [67:36] miss_total, [99:68] evict_total, [103:100] zero
    output logic [sacl_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sacl_pkg::*;

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef line_t [MAX_WAYS-1:0] row_t;

    // Configuration
    logic [2:0]         set_bits_reg;
    logic [4:0]         block_bits_reg;
    logic [3:0]         ways_used_reg;
    logic [2:0]         eff_sb;
    logic [4:0]         eff_ways;

    // Control
    logic               clr_busy_reg;
    logic [SET_W:0]     clr_cnt_reg;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               m_tvalid_reg;
    logic               s_acc;
    logic               s2_fire;

    // Running state
    stamp_t             clock_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   misses_reg;
    logic [CNT_W-1:0]   evicts_reg;
    logic [CNT_W-1:0]   hits_next;
    logic [CNT_W-1:0]   misses_next;
    logic [CNT_W-1:0]   evicts_next;

    // Address split
    logic [5:0]         shift_amt;
    logic [TAG_W-1:0]   in_tag;
    logic [IN_DATA_W-1:0] in_off;
    logic [IN_DATA_W-1:0] in_set_full;
    logic [SET_W-1:0]   in_set;

    // Line memory
    row_t               mem [NUM_SETS];
    row_t               rd_row_reg;
    logic               mem_we;
    logic [SET_W-1:0]   mem_waddr;
    row_t               mem_wdata;

    // Stage 1: row arrives
    logic [KIND_W-1:0]  s1_kind_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    logic [SET_W-1:0]   s1_set_reg;
    logic               s1_fwd_reg;
    row_t               fwd_row_reg;
    row_t               s1_row;
    logic [MAX_WAYS-1:0] s1_match_v;
    logic [MAX_WAYS-1:0] s1_empty_v;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] s1_age;

    // Stage 2: decide and write back
    logic               s2_second_reg;
    logic [TAG_W-1:0]   s2_tag_reg;
    logic [SET_W-1:0]   s2_set_reg;
    row_t               s2_row_reg;
    logic [MAX_WAYS-1:0] s2_match_v_reg;
    logic [MAX_WAYS-1:0] s2_empty_v_reg;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] s2_age_reg;
    logic               s2_hit;
    logic               s2_evict;
    logic [WAY_W-1:0]   s2_way;
    row_t               wr_row;

    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Clamp the configured geometry
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
            eff_sb = 3'(MAX_SET_BITS);
        else
            eff_sb = set_bits_reg;
        if (ways_used_reg == 4'd0)
            eff_ways = 5'd1;
        else if (int'(ways_used_reg) > MAX_WAYS)
            eff_ways = 5'(MAX_WAYS);
        else
            eff_ways = {1'b0, ways_used_reg};
    end

    // Split the address into tag and set
    assign shift_amt   = 6'(eff_sb) + 6'(block_bits_reg);
    assign in_tag      = s_tdata >> shift_amt;
    assign in_off      = s_tdata >> block_bits_reg;
    assign in_set_full = in_off & ~({IN_DATA_W{1'b1}} << eff_sb);
    assign in_set      = in_set_full[SET_W-1:0];

    // Handshakes
    assign s2_fire   = s2_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !clr_busy_reg && !s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Line memory: one row per set, one write and one read port
    assign mem_we    = clr_busy_reg || s2_fire;
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg[SET_W-1:0] : s2_set_reg;
    assign mem_wdata = clr_busy_reg ? row_t'('0) : wr_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (s_acc)
            rd_row_reg <= mem[in_set];
    end

    // Stage 1: take forwarded row if the previous access just wrote this set
    always_comb
    begin
        s1_row = s1_fwd_reg ? fwd_row_reg : rd_row_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (5'(w) < eff_ways)
            begin
                s1_match_v[w] = s1_row[w].valid && (s1_row[w].tag == s1_tag_reg);
                s1_empty_v[w] = !s1_row[w].valid;
            end
            else
            begin
                s1_match_v[w] = 1'b0;
                s1_empty_v[w] = 1'b0;
            end
            if ((5'(w) < eff_ways) && s1_row[w].valid && !s1_match_v[w])
                s1_age[w] = clock_reg - s1_row[w].stamp;
            else
                s1_age[w] = '0;
        end
    end

    // Stage 2: choose a way
    sacl_pick #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W)
    ) u_pick (
        .match_v (s2_match_v_reg),
        .empty_v (s2_empty_v_reg),
        .age     (s2_age_reg),
        .hit     (s2_hit),
        .evict   (s2_evict),
        .way_sel (s2_way)
    );

    // Stamp the chosen way
    always_comb
    begin
        wr_row                = s2_row_reg;
        wr_row[s2_way].valid  = 1'b1;
        wr_row[s2_way].tag    = s2_tag_reg;
        wr_row[s2_way].stamp  = clock_reg;
    end

    // Advance the totals
    assign hits_next   = sat_inc(hits_reg, {1'b0, s2_hit} + {1'b0, s2_second_reg});
    assign misses_next = sat_inc(misses_reg, {1'b0, !s2_hit});
    assign evicts_next = sat_inc(evicts_reg, {1'b0, s2_evict});

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            clock_reg      <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_used_reg  <= WAYS_USED_RST;
        end
        else
        begin
            // Sweep the valid bits after reset
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (SET_W+1)'(NUM_SETS - 1))
                    clr_busy_reg <= 1'b0;
            end

            // Stage 1 always moves on, stage 2 holds for the output
            s1_valid_reg <= s_acc;
            if (s1_valid_reg)
                s2_valid_reg <= 1'b1;
            else if (s2_fire)
                s2_valid_reg <= 1'b0;

            if (s2_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (s2_fire)
            begin
                clock_reg  <= clock_reg + 1'b1;
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                evicts_reg <= evicts_next;
            end

            // Register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                    REG_BLOCK_BITS: block_bits_reg <= cfg_data[4:0];
                    REG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_kind_reg <= s_tuser;
            s1_tag_reg  <= in_tag;
            s1_set_reg  <= in_set;
            s1_fwd_reg  <= s2_fire && (s2_set_reg == in_set);
            fwd_row_reg <= wr_row;
        end
        if (s1_valid_reg)
        begin
            s2_second_reg  <= (s1_kind_reg == KIND_MODIFY);
            s2_tag_reg     <= s1_tag_reg;
            s2_set_reg     <= s1_set_reg;
            s2_row_reg     <= s1_row;
            s2_match_v_reg <= s1_match_v;
            s2_empty_v_reg <= s1_empty_v;
            s2_age_reg     <= s1_age;
        end
        if (s2_fire)
            m_tdata_reg <= {4'b0000, evicts_next, misses_next, hits_next,
                            s2_second_reg, s2_evict, !s2_hit, s2_hit};
    end

`ifndef SYNTHESIS
    // Only one access is in the pipeline between read and write back
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg))
        else $error("two accesses overlap in the row pipeline");

    // No access during the valid-bit sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_tready)
        else $error("access taken during clearing sweep");

    // An accepted access reaches the row stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (s1_valid_reg && !s_tready))
        else $error("accepted access lost before row stage");
`endif

endmodule

// ----- tb/set_assoc_cache_lru_model_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_cache_lru_model: a directed table, then random
// access phases under several cache geometries, checked against an LRU cache predictor.
// Depends on sacl_pkg and the set_assoc_cache_lru_model RTL only.
module set_assoc_cache_lru_model_tb;

    import sacl_pkg::*;

    localparam int SET_BITS_MAX  = 6;
    localparam int WAYS_MAX      = 8;
    localparam int LINES         = (1 << SET_BITS_MAX) * WAYS_MAX;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_LIMIT    = 2000;
    localparam int N_DIRECTED    = 14;
    localparam int N_FIXED       = 8;
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 140;
    localparam int TAIL_CYCLES   = 8;
    localparam int REPORT_LINES  = 100;

    // Access kinds; modify comes from the package
    localparam logic [KIND_W-1:0] ACC_LOAD     = 2'd0;
    localparam logic [KIND_W-1:0] ACC_STORE    = 2'd1;
    localparam logic [KIND_W-1:0] ACC_RESERVED = 2'd3;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        eviction;
        logic        second_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } outcome_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [63:0]       addr;
        logic              checked;
        outcome_t          want;
    } access_row_t;

    typedef struct packed {
        logic [4:0] set_bits;
        logic [4:0] block_bits;
        logic [4:0] ways;
    } geometry_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;    // [63:0] address
    logic [KIND_W-1:0]       s_tuser = '0;    // [1:0] kind
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [0] hit, [1] miss, [2] eviction, [3] second_hit, [35:4] hit_total,
    // [67:36] miss_total, [99:68] evict_total, [103:100] zero
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // Predictor state
    logic        line_valid_q [LINES] = '{default: 1'b0};
    logic [63:0] line_tag_q   [LINES];
    logic [31:0] line_stamp_q [LINES];
    logic [31:0] stamp_clock = '0;
    logic [31:0] hit_tally = '0;
    logic [31:0] miss_tally = '0;
    logic [31:0] evict_count = '0;
    logic [2:0]  cur_set_bits = SET_BITS_RST;
    logic [4:0]  cur_block_bits = BLOCK_BITS_RST;
    logic [3:0]  cur_ways = WAYS_USED_RST;

    outcome_t pending_outcomes [$];
    int       mismatch_count = 0;
    int       accesses_sent = 0;
    int       outcomes_seen = 0;
    int       shared_tag_hits = 0;
    int       burst_left = 0;
    int       idle_cycles = 0;

    // Reset-time geometry: 16 sets, 16-byte lines, one way
    access_row_t directed_rows [N_DIRECTED] = '{
        '{ACC_LOAD,     64'h0000_0000_0000_0000, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0}},
        '{ACC_LOAD,     64'h0000_0000_0000_000F, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
        '{KIND_MODIFY,  64'h0000_0000_0000_0008, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 32'd3, 32'd1, 32'd0}},
        '{ACC_STORE,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 32'd3, 32'd2, 32'd0}},
        '{ACC_RESERVED, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd4, 32'd2, 32'd0}},
        '{ACC_LOAD,     64'h0000_0000_0000_0100, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 32'd4, 32'd3, 32'd1}},
        '{KIND_MODIFY,  64'h0000_0000_0000_0200, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 32'd5, 32'd4, 32'd2}},
        '{ACC_LOAD,     64'h0000_0000_0000_0000, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 32'd5, 32'd5, 32'd3}},
        '{ACC_STORE,    64'h8000_0000_0000_0000, 1'b0, '0},
        '{ACC_LOAD,     64'h5555_5555_5555_5555, 1'b0, '0},
        '{KIND_MODIFY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{ACC_RESERVED, 64'h0000_0000_0000_00F0, 1'b0, '0},
        '{ACC_LOAD,     64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ACC_LOAD,     64'h8000_0000_0000_0000, 1'b0, '0}
    };

    // Geometries for the first phases; later phases draw random ones
    geometry_t fixed_geometries [N_FIXED] = '{
        '{5'd0,  5'd0,  5'd1},     // one set, one way, no offset
        '{5'd6,  5'd16, 5'd8},     // widest set and way counts
        '{5'd2,  5'd3,  5'd4},
        '{5'd2,  5'd3,  5'd2},     // shrink: upper ways keep their lines
        '{5'd2,  5'd3,  5'd8},     // grow again: stale copies become visible
        '{5'd31, 5'd31, 5'd31},    // out of range: set and way counts clamp
        '{5'd3,  5'd20, 5'd0},     // zero ways acts as one
        '{5'd1,  5'd2,  5'd15}
    };

    set_assoc_cache_lru_model #(
        .MAX_SET_BITS (SET_BITS_MAX),
        .MAX_WAYS     (WAYS_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_set_bits();
        return (cur_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(cur_set_bits);
    endfunction

    function automatic int eff_ways();
        if (cur_ways == 0)
            return 1;
        return (cur_ways > WAYS_MAX) ? WAYS_MAX : int'(cur_ways);
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] count);
        return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
    endfunction

    // Look up one access in the shadow cache, update LRU stamps and totals
    function automatic outcome_t predict_access(input logic [KIND_W-1:0] kind,
                                                input logic [63:0] addr);
        int          sb;
        int          ways;
        int          base;
        int          match;
        int          empty;
        int          victim;
        int          slot;
        int          copies;
        logic [63:0] tag;
        logic [31:0] oldest;
        logic [31:0] age;
        outcome_t    res;
        sb     = eff_set_bits();
        ways   = eff_ways();
        tag    = addr >> (sb + int'(cur_block_bits));
        base   = int'((addr >> cur_block_bits) & ((64'd1 << sb) - 64'd1)) * WAYS_MAX;
        match  = -1;
        empty  = -1;
        victim = 0;
        copies = 0;
        oldest = '0;
        res    = '0;
        for (int w = 0; w < ways; w++)
        begin
            if (line_valid_q[base + w])
            begin
                if (line_tag_q[base + w] == tag)
                begin
                    copies++;
                    if (match < 0)
                        match = w;
                end
                else
                begin
                    // Oldest stamp wins, lowest way on a tie
                    age = stamp_clock - line_stamp_q[base + w];
                    if (age > oldest)
                    begin
                        oldest = age;
                        victim = w;
                    end
                end
            end
            else if (empty < 0)
            begin
                empty = w;
            end
        end
        if (copies > 1)
            shared_tag_hits++;
        if (match >= 0)
        begin
            res.hit = 1'b1;
            hit_tally = bump(hit_tally);
            line_stamp_q[base + match] = stamp_clock;
        end
        else
        begin
            slot = base + ((empty >= 0) ? empty : victim);
            res.miss = 1'b1;
            miss_tally = bump(miss_tally);
            if (empty < 0)
            begin
                res.eviction = 1'b1;
                evict_count = bump(evict_count);
            end
            line_valid_q[slot] = 1'b1;
            line_tag_q[slot]   = tag;
            line_stamp_q[slot] = stamp_clock;
        end
        stamp_clock = stamp_clock + 32'd1;
        if (kind == KIND_MODIFY)
        begin
            res.second_hit = 1'b1;
            hit_tally = bump(hit_tally);
        end
        res.hit_total   = hit_tally;
        res.miss_total  = miss_tally;
        res.evict_total = evict_count;
        return res;
    endfunction

    // Sender gap: mostly none or short, rarely long, with gap-free bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(40, 100);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < REPORT_LINES)
            $display("[%0t] mismatch on %s at outcome %0d: got %0h, expected %0h",
                     $time, what, outcomes_seen, got, want);
        mismatch_count++;
    endtask

    // Send one access, then queue its outcome (typed-in or predicted)
    task automatic send_access(input logic [KIND_W-1:0] kind, input logic [63:0] addr,
                               input logic checked, input outcome_t want, input int gap);
        outcome_t pred;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        pred = predict_access(kind, addr);
        pending_outcomes.push_back(checked ? want : pred);
        accesses_sent++;
    endtask

    // Write all registers plus the spare index; only called while idle
    task automatic apply_geometry(input geometry_t g);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx[0] = REG_SET_BITS;
        val[0] = g.set_bits;
        idx[1] = REG_BLOCK_BITS;
        val[1] = g.block_bits;
        idx[2] = REG_WAYS_USED;
        val[2] = g.ways;
        idx[3] = REG_SPARE;
        val[3] = CFG_DATA_W'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                REG_SET_BITS:   cur_set_bits   = val[i][2:0];
                REG_BLOCK_BITS: cur_block_bits = val[i][4:0];
                REG_WAYS_USED:  cur_ways       = val[i][3:0];
                default:        ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Compare each accepted outcome with the oldest pending one
    always @(posedge clk)
    begin : check_outcome
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit         = m_tdata[0];
            got.miss        = m_tdata[1];
            got.eviction    = m_tdata[2];
            got.second_hit  = m_tdata[3];
            got.hit_total   = m_tdata[35:4];
            got.miss_total  = m_tdata[67:36];
            got.evict_total = m_tdata[99:68];
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected outcome", m_tdata[63:0], '0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                if (got.miss !== want.miss)
                    report_mismatch("miss", 64'(got.miss), 64'(want.miss));
                if (got.eviction !== want.eviction)
                    report_mismatch("eviction", 64'(got.eviction), 64'(want.eviction));
                if (got.second_hit !== want.second_hit)
                    report_mismatch("second_hit", 64'(got.second_hit),
                                    64'(want.second_hit));
                if (got.hit_total !== want.hit_total)
                    report_mismatch("hit_total", 64'(got.hit_total), 64'(want.hit_total));
                if (got.miss_total !== want.miss_total)
                    report_mismatch("miss_total", 64'(got.miss_total),
                                    64'(want.miss_total));
                if (got.evict_total !== want.evict_total)
                    report_mismatch("evict_total", 64'(got.evict_total),
                                    64'(want.evict_total));
            end
            outcomes_seen++;
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: ready runs and stalls of random length
    initial
    begin : drain_side
        int ready_len;
        int stall_len;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            ready_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                                     : $urandom_range(30, 150);
            stall_len = $urandom_range(0, 99);
            stall_len = (stall_len < 75) ? $urandom_range(1, 3) :
                        (stall_len < 95) ? $urandom_range(4, 10) : $urandom_range(20, 60);
            m_tready <= 1'b1;
            repeat (ready_len) @(posedge clk);
            m_tready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        geometry_t   g;
        logic [63:0] tag_base;
        logic [63:0] tag_pick;
        logic [63:0] set_pick;
        logic [63:0] offs;
        logic [63:0] addr;
        int          set_lo;
        int          set_span;
        int          n_tags;
        int          sh;

        // Hold reset, then release on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset geometry
        for (int i = 0; i < N_DIRECTED; i++)
            send_access(directed_rows[i].kind, directed_rows[i].addr,
                        directed_rows[i].checked, directed_rows[i].want, pick_gap());

        tag_base = '0;
        set_lo   = 0;
        set_span = 1;
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            // Reconfigure only once every outcome is back
            wait_drained();
            if (phase < N_FIXED)
            begin
                g = fixed_geometries[phase];
            end
            else
            begin
                g.set_bits   = 5'($urandom_range(0, 7));
                g.block_bits = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 16))
                                                           : 5'($urandom_range(17, 31));
                g.ways       = 5'($urandom_range(0, 15));
            end
            apply_geometry(g);

            // Keep the tag pool across some phases so lines get reinterpreted
            if (phase == 0 || phase == 5 || (phase >= N_FIXED && $urandom_range(0, 1) == 1))
            begin
                tag_base = {$urandom, $urandom};
                set_lo   = $urandom_range(0, (1 << SET_BITS_MAX) - 1);
                set_span = $urandom_range(1, 3);
            end
            n_tags = eff_ways() + $urandom_range(0, 3);
            sh     = eff_set_bits() + int'(cur_block_bits);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    // Reuse a small tag pool over a few sets to force hits and evictions
                    tag_pick = tag_base + 64'($urandom_range(0, n_tags - 1));
                    set_pick = 64'((set_lo + $urandom_range(0, set_span - 1))
                                   & ((1 << eff_set_bits()) - 1));
                    offs     = {$urandom, $urandom} & ((64'd1 << cur_block_bits) - 64'd1);
                    addr     = (tag_pick << sh) | (set_pick << cur_block_bits) | offs;
                end
                else
                begin
                    addr = {$urandom, $urandom};
                end
                send_access(KIND_W'($urandom_range(0, 3)), addr, 1'b0, '0, pick_gap());
            end
        end

        // Drain, then let the pipeline settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d accesses over %0d geometries: %0d hits, %0d misses, %0d evictions",
                 accesses_sent, N_PHASES + 1, hit_tally, miss_tally, evict_count);
        $display("checked %0d outcomes; %0d lookups saw the same tag in several ways",
                 outcomes_seen, shared_tag_hits);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
